// File: sv/md5_pkg.sv
// Package: shared types, constants and round tables for the MD5 engine.
`timescale 1ns / 1ps
package md5_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS  = 6'd56;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  // Command from front end to back end.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       finish;
  } cmd_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hD76AA478;  6'd1: k = 32'hE8C7B756;  6'd2: k = 32'h242070DB;
      6'd3: k = 32'hC1BDCEEE;  6'd4: k = 32'hF57C0FAF;  6'd5: k = 32'h4787C62A;
      6'd6: k = 32'hA8304613;  6'd7: k = 32'hFD469501;  6'd8: k = 32'h698098D8;
      6'd9: k = 32'h8B44F7AF;  6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193; 6'd14: k = 32'hA679438E;
      6'd15: k = 32'h49B40821; 6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA; 6'd20: k = 32'hD62F105D;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6; 6'd26: k = 32'hF4D50D87;
      6'd27: k = 32'h455A14ED; 6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A; 6'd32: k = 32'hFFFA3942;
      6'd33: k = 32'h8771F681; 6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9; 6'd38: k = 32'hF6BB4B60;
      6'd39: k = 32'hBEBFBC70; 6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05; 6'd44: k = 32'hD9D4D039;
      6'd45: k = 32'hE6DB99E5; 6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97; 6'd50: k = 32'hAB9423A7;
      6'd51: k = 32'hFC93A039; 6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1; 6'd56: k = 32'h6FA87E4F;
      6'd57: k = 32'hFE2CE6E0; 6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235; 6'd62: k = 32'h2AD7D2BB;
      default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index for step i.
  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
      default: g = 4'(i[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage

// File: sv/md5_ifc.sv
// Valid/ready channel interfaces for the MD5 engine.
`timescale 1ns / 1ps
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: sv/md5_front.sv
// Front end: takes input transactions, drops idle ones, queues commands.
`timescale 1ns / 1ps
module md5_front
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  md5_in_if.sink      in_ch,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);
  cmd_t             q_r [QDEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QAW:0]     cnt_r;
  logic             push;

  assign in_ch.ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign push = in_ch.valid && in_ch.ready && (in_ch.byte_present || in_ch.end_of_message);
  assign cmd_valid = (cnt_r != '0);
  assign cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= '{data: in_ch.data_byte, present: in_ch.byte_present,
                             finish: in_ch.end_of_message};
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (cmd_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(cmd_pop);
    end
  end
endmodule

// File: sv/md5_back.sv
// Back end: byte packing, padding, 64-step compression and digest output.
`timescale 1ns / 1ps
module md5_back
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  md5_out_if.source   out_ch
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_PAD = 6'b000010, S_LEN = 6'b000100,
    S_RND  = 6'b001000, S_FIN = 6'b010000, S_OUT = 6'b100000
  } st_t;

  st_t          st_r, st_nxt;
  logic [31:0]  buf_r [16];
  logic [31:0]  h_r [4];
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [63:0]  cnt_r, len_r;
  logic [5:0]   i_r;
  logic [2:0]   lk_r;
  logic         fin_r;    // padding in progress, emit after final block
  logic [1:0]   oi_r;
  logic         ov_r;

  logic [5:0]   pos;
  logic         wr_en;
  logic [7:0]   wr_byte;
  logic [31:0]  f, sum, rot, g_word;

  assign pos = cnt_r[8:3];
  assign cmd_pop = (st_r == S_IDLE) && cmd_valid;

  always_comb begin
    wr_en = 1'b0; wr_byte = cmd.data;
    unique case (st_r)
      S_IDLE: begin
        wr_en = cmd_valid && cmd.present;
        wr_byte = cmd.data;
      end
      S_PAD: begin
        wr_en = 1'b1;
        // marker byte goes right where the message ended
        wr_byte = (cnt_r == len_r) ? PAD_BYTE : 8'h00;
      end
      S_LEN: begin
        wr_en = 1'b1;
        wr_byte = len_r[8*lk_r +: 8];
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (i_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    g_word = buf_r[round_g(i_r)];
    sum = a_r + f + g_word + round_k(i_r);
    rot = (sum << round_s(i_r)) | (sum >> (6'd32 - {1'b0, round_s(i_r)}));
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (cmd_valid) begin
        if (cmd.present && pos == 6'd63) st_nxt = S_RND;
        else if (cmd.finish) st_nxt = S_PAD;
      end
      S_PAD: begin
        if (pos == 6'd63) st_nxt = S_RND;
        else if (pos + 6'd1 == LEN_POS) st_nxt = S_LEN;
      end
      S_LEN: if (lk_r == 3'd7) st_nxt = S_RND;
      S_RND: if (i_r == 6'd63) st_nxt = S_FIN;
      S_FIN: begin
        if (!fin_r) st_nxt = S_IDLE;
        else if (pos == 6'd0 && cnt_r != len_r + 64'd8 && lk_r == 3'd0 && len_r[0])
          st_nxt = S_OUT;
        else if (pos == LEN_POS) st_nxt = S_LEN;
        else st_nxt = S_PAD;
      end
      S_OUT: if (out_ch.ready && oi_r == 2'd3) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // len_r[0] is used as the "length already written" flag (bit count is a
  // multiple of 8, so bit 0 of the saved length is free).
  always_ff @(posedge clk) begin
    if (wr_en)
      buf_r[pos[5:2]][8*pos[1:0] +: 8] <= wr_byte;
    if (st_r == S_RND) begin
      a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
    end
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; len_r <= '0; i_r <= '0; lk_r <= '0;
      fin_r <= 1'b0; oi_r <= '0; ov_r <= 1'b0;
      h_r[0] <= IV0; h_r[1] <= IV1; h_r[2] <= IV2; h_r[3] <= IV3;
    end else begin
      st_r <= st_nxt;
      if (wr_en) cnt_r <= cnt_r + 64'd8;
      if (st_r == S_IDLE && cmd_valid && cmd.finish) begin
        len_r <= cnt_r + (cmd.present ? 64'd8 : 64'd0);
        fin_r <= 1'b1;
      end
      if (st_r == S_LEN) begin
        lk_r <= lk_r + 3'd1;
        if (lk_r == 3'd7) len_r[0] <= 1'b1;
      end
      if (st_nxt == S_RND && st_r != S_RND) begin
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
        i_r <= '0;
      end else if (st_r == S_RND) i_r <= i_r + 6'd1;
      if (st_r == S_FIN) begin
        h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r; h_r[3] <= h_r[3] + d_r;
        if (st_nxt == S_OUT) begin ov_r <= 1'b1; oi_r <= '0; end
      end
      if (st_r == S_OUT && out_ch.ready) begin
        oi_r <= oi_r + 2'd1;
        if (oi_r == 2'd3) begin
          ov_r <= 1'b0; fin_r <= 1'b0; cnt_r <= '0; len_r <= '0;
          h_r[0] <= IV0; h_r[1] <= IV1; h_r[2] <= IV2; h_r[3] <= IV3;
        end
      end
    end
  end

  assign out_ch.valid = ov_r && (st_r == S_OUT);
  assign out_ch.digest_word = h_r[oi_r];
  assign out_ch.word_index = oi_r;
  assign out_ch.last_word = (oi_r == 2'd3);
endmodule

// File: sv/md5_hash_engine.sv
// Top level of the MD5 engine: front queue plus compression back end.
//
//  channel | dir | payload
//  in_ch   | in  | data_byte[7:0], byte_present, end_of_message
//  out_ch  | out | digest_word[31:0], word_index[1:0], last_word
//
// Each data byte goes into the block buffer; a full block then runs the
// rounds and a finalize step (one shared round unit). End of message pads
// byte by byte before the digest leaves as four output beats.
// A four-entry command queue lets input keep flowing while rounds run.
// Reset is synchronous, active low; the block buffer is not cleared.
`timescale 1ns / 1ps
module md5_hash_engine
  import md5_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  md5_in_if.sink     in_ch,
  md5_out_if.source  out_ch
);
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  md5_front u_front (.clk, .rst_n, .in_ch, .cmd_valid, .cmd, .cmd_pop);
  md5_back  u_back  (.clk, .rst_n, .cmd_valid, .cmd, .cmd_pop, .out_ch);
endmodule

// File: sv/md5_checker.sv
// Port-level checker for the MD5 engine, bound to the top level.
`timescale 1ns / 1ps
module md5_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        o_valid,
  input logic        o_ready,
  input logic [1:0]  o_idx,
  input logic        o_last,
  input logic [31:0] o_word
);
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> (o_last == (o_idx == 2'd3))) else $error("last_word mismatch");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && o_ready && !o_last |=> o_valid && o_idx == $past(o_idx) + 2'd1)
    else $error("digest words out of order");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_ready |=> o_valid && $stable(o_word) && $stable(o_idx))
    else $error("stalled output changed");
endmodule

bind md5_hash_engine md5_port_checker u_chk (
  .clk, .rst_n, .o_valid(out_ch.valid), .o_ready(out_ch.ready),
  .o_idx(out_ch.word_index), .o_last(out_ch.last_word), .o_word(out_ch.digest_word));

// File: test/md5_checker.sv
// Checker: watches both channels, predicts MD5 digests and compares results.
`timescale 1ns / 1ps
module md5_checker
  import md5_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  md5_in_if.sink    in_mon,
  md5_out_if.sink   out_mon,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_beat_t;

  localparam logic [31:0] STEP_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };
  localparam int STEP_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  logic [31:0]  chain [4];
  logic [31:0]  msg_words [16];
  logic [63:0]  msg_bits;
  digest_beat_t digest_q [$];

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic compress_block();
    logic [31:0] a, b, c, d, f, sum, nb;
    int g;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d;          g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      sum = a + f + msg_words[g] + STEP_K[i];
      nb = b + rotl(sum, STEP_S[(i / 16) * 4 + i % 4]);
      a = d; d = c; c = b; b = nb;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic absorb(input logic [7:0] byte_val);
    logic [5:0] pos;
    pos = msg_bits[8:3];
    msg_words[pos[5:2]][pos[1:0] * 8 +: 8] = byte_val;
    msg_bits += 64'd8;
    if (pos == 6'd63) compress_block();
  endtask

  task automatic restart_message();
    chain[0] = IV0; chain[1] = IV1; chain[2] = IV2; chain[3] = IV3;
    msg_bits = '0;
  endtask

  task automatic predict_item(input logic [7:0] data, input logic present, input logic finish);
    logic [63:0] length;
    if (present) absorb(data);
    if (finish) begin
      length = msg_bits;
      absorb(PAD_BYTE);
      while (msg_bits[8:3] != LEN_POS) absorb(8'h00);
      for (int k = 0; k < 8; k++) absorb(length[8 * k +: 8]);
      for (int k = 0; k < 4; k++) digest_q.push_back('{chain[k], 2'(k), k == 3});
      restart_message();
    end
  endtask

  initial begin
    fail_count = 0;
    restart_message();
    foreach (msg_words[i]) msg_words[i] = '0;
  end

  assign pending = digest_q.size();

  always @(posedge clk) begin
    digest_beat_t exp_beat, got;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        predict_item(in_mon.data_byte, in_mon.byte_present, in_mon.end_of_message);
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.digest_word, out_mon.word_index, out_mon.last_word};
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest transaction, actual %h/%0d/%0d", $time,
                   got.word, got.index, got.last);
          fail_count++;
        end else begin
          exp_beat = digest_q.pop_front();
          if (got !== exp_beat) begin
            $display("%0t: digest mismatch, expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                     exp_beat.word, exp_beat.index, exp_beat.last,
                     got.word, got.index, got.last);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: test/testbench.sv
// Testbench top: clock, reset, byte-stream stimulus, idling and final verdict.
`timescale 1ns / 1ps
module testbench;
  import md5_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 19;
  int   recv_idle_pct = 53;
  logic hold_off = 1'b0;

  md5_in_if  in_ch ();
  md5_out_if out_ch ();

  md5_hash_engine dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source));
  md5_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
                   .fail_count(fail_count), .pending(pending));

  always #6 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_present = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready = 1'b0;
  end

  // receiver ready, random stalls plus long hold-off window
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one transaction, honoring sender idle percentage; returns after acceptance.
  task automatic send_item(input logic [7:0] data, input logic present, input logic finish);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.byte_present <= present;
    in_ch.end_of_message <= finish;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_message(input int len);
    logic merged;
    merged = 1'b0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      merged = (i == len - 1) && ($urandom_range(1) == 1);
      send_item(8'($urandom_range(255)), 1'b1, merged);
    end
    // end may come alone when not merged with the final byte
    if (!merged) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic random_phase(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: len = $urandom_range(60, 70);
        1: len = $urandom_range(110, 130);
        default: len = $urandom_range(0, 12);
      endcase
      send_message(len);
      sent += len + 1;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty message, idle items, byte-and-end merged, extremes of bytes
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    // padding boundary: 55 and 56 bytes
    send_message(55);
    send_message(56);
    // long receiver hold-off while input keeps flowing
    hold_off <= 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int m = 0; m < 6; m++) send_message($urandom_range(0, 3));
    join
    random_phase(90);
    send_idle_pct = 53;
    recv_idle_pct = 19;
    random_phase(90);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(40);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
